/* hdl/pfgp_pkg.sv */
`default_nettype none

package pfgp_pkg;

    // payload widths fixed by the stream format
    localparam int VALUE_W   = 32;
    localparam int GSIZE_W   = 6;
    localparam int STORE_W   = 31;   // primes are non-negative, sign bit not stored
    localparam int DIVISOR_W = 16;   // largest trial divisor is 46341
    localparam int SQUARE_W  = 32;
    localparam int BITCNT_W  = 5;    // indexes the 31 dividend bits

    localparam int MAX_GROUP_DEF = 32;

    localparam logic [GSIZE_W-1:0]   GROUP_SIZE_RST = 6'd3;
    localparam logic [VALUE_W-1:0]   PAD_ELEMENT    = 32'hFFFF_FFFF;
    localparam logic [DIVISOR_W-1:0] FIRST_DIVISOR  = 16'd2;
    localparam logic [SQUARE_W-1:0]  FIRST_SQUARE   = 32'd4;

endpackage : pfgp_pkg

`default_nettype wire

/* hdl/prime_filter_group_packer_top.sv */
`default_nettype none
// Operation: a value is tested by trial division; each divisor takes a square check
// and then a pass through the bit-serial remainder unit, so a 31-bit prime near 2^31
// is tried against every divisor up to 46340, smaller values and composites far fewer.
// Each group element takes a buffer read and a load; a termination transaction follows.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset: synchronous active-low aresetn; group_size returns to 3, buffer empties.

module prime_filter_group_packer_top #(
    parameter int MAX_GROUP = pfgp_pkg::MAX_GROUP_DEF   // 1 .. 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // configuration: group_size
    input  wire logic                           cfg_wen,
    input  wire logic [pfgp_pkg::GSIZE_W-1:0]   cfg_wdata,

    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pfgp_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value (signed)
    input  wire logic                           s_tlast,   // end_of_input

    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pfgp_pkg::VALUE_W-1:0]        m_tdata,   // [31:0] element (signed)
    output logic                                m_tlast,   // last_in_group
    output logic                                m_tuser    // [0] stream_end
);

    // fill count and group index hold 0 .. MAX_GROUP
    localparam int CW = $clog2(MAX_GROUP + 1);
    // buffer address
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for an input transaction
        ST_CHECK = 6'b000010,   // compare divisor squared against the value
        ST_DIV   = 6'b000100,   // shared remainder unit, one dividend bit per cycle
        ST_RD    = 6'b001000,   // buffer read for the next group element
        ST_LOAD  = 6'b010000,   // move the element into the output register
        ST_TERM  = 6'b100000    // termination transaction
    } state_t;

    state_t state_reg, state_next;

    logic [pfgp_pkg::GSIZE_W-1:0]   group_size_reg;
    logic [CW-1:0]                  fill_reg, fill_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  total_reg, total_next;
    logic                           term_pend_reg, term_pend_next;

    // trial division datapath
    logic [pfgp_pkg::STORE_W-1:0]   n_reg, n_next;
    logic [pfgp_pkg::DIVISOR_W-1:0] d_reg, d_next;
    logic [pfgp_pkg::SQUARE_W-1:0]  sq_reg, sq_next;
    logic [pfgp_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [pfgp_pkg::BITCNT_W-1:0]  bit_reg, bit_next;

    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [pfgp_pkg::VALUE_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;
    logic                           m_tuser_reg, m_tuser_next;

    // group buffer
    logic [pfgp_pkg::STORE_W-1:0]   buf_mem [MAX_GROUP];
    logic [pfgp_pkg::STORE_W-1:0]   rd_data_reg;
    logic                           buf_we;
    logic                           buf_re;

    logic [CW-1:0]                  eff_size;
    logic [pfgp_pkg::DIVISOR_W:0]   rem_shift;
    logic [pfgp_pkg::DIVISOR_W:0]   rem_sub;
    logic [pfgp_pkg::DIVISOR_W-1:0] rem_step;
    logic                           out_free;
    logic                           in_txn;
    logic [CW:0]                    fill_inc;
    logic [CW:0]                    idx_inc;

    // effective group size: zero counts as one, saturate at buffer depth
    always_comb begin
        if (group_size_reg == '0) begin
            eff_size = CW'(1);
        end else if (32'(group_size_reg) > 32'(MAX_GROUP)) begin
            eff_size = CW'(MAX_GROUP);
        end else begin
            eff_size = CW'(group_size_reg);
        end
    end

    assign in_txn   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fill_inc = {1'b0, fill_reg} + (CW+1)'(1);
    assign idx_inc  = {1'b0, idx_reg} + (CW+1)'(1);

    // one restoring step of the shared remainder unit
    assign rem_shift = {rem_reg, n_reg[bit_reg]};
    assign rem_sub   = rem_shift - {1'b0, d_reg};
    assign rem_step  = (rem_shift >= {1'b0, d_reg}) ? rem_sub[pfgp_pkg::DIVISOR_W-1:0]
                                                    : rem_shift[pfgp_pkg::DIVISOR_W-1:0];

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        term_pend_next = term_pend_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;
        buf_we         = 1'b0;
        buf_re         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_txn) begin
                    if (s_tlast) begin
                        if (fill_reg != '0) begin
                            total_next     = (fill_reg > eff_size) ? fill_reg : eff_size;
                            idx_next       = '0;
                            term_pend_next = 1'b1;
                            state_next     = ST_RD;
                        end else begin
                            state_next = ST_TERM;
                        end
                    end else if (!s_tdata[pfgp_pkg::VALUE_W-1] &&
                                 s_tdata > pfgp_pkg::VALUE_W'(1)) begin
                        n_next     = s_tdata[pfgp_pkg::STORE_W-1:0];
                        d_next     = pfgp_pkg::FIRST_DIVISOR;
                        sq_next    = pfgp_pkg::FIRST_SQUARE;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                if (sq_reg > {1'b0, n_reg}) begin
                    // no divisor found: prime
                    if (32'(fill_reg) < 32'(MAX_GROUP)) begin
                        buf_we    = 1'b1;
                        fill_next = fill_inc[CW-1:0];
                    end
                    if (fill_next >= eff_size) begin
                        total_next     = fill_next;
                        idx_next       = '0;
                        term_pend_next = 1'b0;
                        state_next     = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    rem_next   = '0;
                    bit_next   = pfgp_pkg::BITCNT_W'(pfgp_pkg::STORE_W - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                rem_next = rem_step;
                bit_next = bit_reg - pfgp_pkg::BITCNT_W'(1);
                if (bit_reg == '0) begin
                    if (rem_step == '0) begin
                        state_next = ST_IDLE;   // composite
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + pfgp_pkg::SQUARE_W'({d_reg, 1'b1});
                        d_next     = d_reg + pfgp_pkg::DIVISOR_W'(1);
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_RD: begin
                buf_re     = (idx_reg < fill_reg);
                state_next = ST_LOAD;
            end

            ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (idx_reg < fill_reg) ? {1'b0, rd_data_reg}
                                                         : pfgp_pkg::PAD_ELEMENT;
                    m_tlast_next  = (idx_inc == {1'b0, total_reg});
                    m_tuser_next  = 1'b0;
                    idx_next      = idx_inc[CW-1:0];
                    if (idx_inc == {1'b0, total_reg}) begin
                        fill_next  = '0;
                        state_next = term_pend_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end

            ST_TERM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pfgp_pkg::PAD_ELEMENT;
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b1;
                    fill_next     = '0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            group_size_reg <= pfgp_pkg::GROUP_SIZE_RST;
            fill_reg       <= '0;
            term_pend_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            term_pend_reg <= term_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wen) begin
                group_size_reg <= cfg_wdata;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    // group buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[fill_reg[AW-1:0]] <= n_reg;
        end
        if (buf_re) begin
            rd_data_reg <= buf_mem[idx_reg[AW-1:0]];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // termination transaction always carries -1 and no group marker
    a_term_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == pfgp_pkg::PAD_ELEMENT && !m_tlast))
        else $error("termination transaction malformed");

    // buffer never holds more than its depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= 32'(MAX_GROUP))
        else $error("fill count beyond buffer depth");

    // partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < d_reg && d_reg >= pfgp_pkg::FIRST_DIVISOR))
        else $error("remainder unit out of range");

    // group index stays below the group length while an element is loaded
    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (idx_reg < total_reg))
        else $error("group index past group length");

endmodule : prime_filter_group_packer_top

`default_nettype wire

/* tb/sv/prime_filter_group_packer_top_tb.sv */
`default_nettype none

module prime_filter_group_packer_top_tb;

    localparam int GROUP_CAP = pfgp_pkg::MAX_GROUP_DEF;

    // one input transaction: value in s_tdata, end of input on s_tlast
    typedef struct packed {
        logic [pfgp_pkg::VALUE_W-1:0] value;
        logic                         eoi;
    } stream_item_t;

    // one result transaction: m_tdata, m_tlast, m_tuser[0]
    typedef struct packed {
        logic [pfgp_pkg::VALUE_W-1:0] element;
        logic                         group_end;
        logic                         stream_end;
    } packed_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wen   = 1'b0;
    logic [pfgp_pkg::GSIZE_W-1:0]   cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [pfgp_pkg::VALUE_W-1:0]   s_tdata   = '0;   // [31:0] value (signed)
    logic                           s_tlast   = 1'b0; // end_of_input
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [pfgp_pkg::VALUE_W-1:0]   m_tdata;          // [31:0] element (signed)
    logic                           m_tlast;          // last_in_group
    logic                           m_tuser;          // [0] stream_end

    prime_filter_group_packer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state: mirror of the packer's group buffer and size register.
    logic [pfgp_pkg::STORE_W-1:0]   held_primes [GROUP_CAP];
    int unsigned                    held_count       = 0;
    logic [pfgp_pkg::GSIZE_W-1:0]   group_size_model = pfgp_pkg::GROUP_SIZE_RST;

    stream_item_t         pending_items [$];
    packed_result_t       expected_results [$];

    int                   mismatch_count = 0;
    int unsigned          primes_queued  = 0;
    bit                   idling_on      = 1'b1;
    int unsigned          src_gap        = 0;
    int unsigned          sink_stall     = 0;

    function automatic bit is_prime(logic [pfgp_pkg::VALUE_W-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v[pfgp_pkg::VALUE_W-1] || v <= 1)
            return 1'b0;
        n = v;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // mostly small primes so trial division stays cheap; some up to 2^16
    function automatic logic [pfgp_pkg::VALUE_W-1:0] random_prime();
        logic [pfgp_pkg::VALUE_W-1:0] x;
        x = ($urandom_range(0, 4) == 0) ? $urandom_range(4096, 65520) : $urandom_range(2, 4095);
        while (!is_prime(x))
            x++;
        return x;
    endfunction

    // Emit the held primes as one group of 'total' elements, padded with -1.
    task automatic emit_held_group(int unsigned total);
        packed_result_t r;
        for (int unsigned i = 0; i < total; i++) begin
            r.element    = (i < held_count) ? {1'b0, held_primes[i]} : pfgp_pkg::PAD_ELEMENT;
            r.group_end  = (i + 1 == total);
            r.stream_end = 1'b0;
            expected_results.push_back(r);
        end
        held_count = 0;
    endtask

    task automatic push_item(logic [pfgp_pkg::VALUE_W-1:0] value, logic eoi);
        stream_item_t it;
        it.value = value;
        it.eoi   = eoi;
        pending_items.push_back(it);
        if (!eoi && is_prime(value))
            primes_queued++;
    endtask

    // Random stream content: prime_pct percent primes, eoi_pct percent end markers,
    // the rest composites, negatives, 0 or 1, and wide even values.
    task automatic queue_random_items(int count, int prime_pct, int eoi_pct, bit close_stream);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < eoi_pct)
                push_item($urandom, 1'b1);
            else if (roll < eoi_pct + prime_pct)
                push_item(random_prime(), 1'b0);
            else begin
                case ($urandom_range(0, 4))
                    0: push_item({1'b1, 31'($urandom)}, 1'b0);
                    1: push_item($urandom_range(0, 1), 1'b0);
                    2: push_item($urandom & 32'hFFFF_FFFE, 1'b0);
                    3: push_item($urandom_range(2, 250) * $urandom_range(2, 250), 1'b0);
                    default: push_item(32'($urandom_range(2, 715827882)) * 3, 1'b0);
                endcase
            end
        end
        if (close_stream)
            push_item($urandom, 1'b1);
    endtask

    // Wait until every transaction is taken, the sequencer is back to idle and
    // every expected result has been checked; sampled between edges.
    task automatic wait_until_drained();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || !s_tready || m_tvalid ||
               expected_results.size() != 0);
    endtask

    task automatic set_group_size(logic [pfgp_pkg::GSIZE_W-1:0] size);
        wait_until_drained();
        @(posedge aclk);
        cfg_wen          <= 1'b1;
        cfg_wdata        <= size;
        group_size_model  = size;
        @(posedge aclk);
        cfg_wen          <= 1'b0;
    endtask

    // Input driver: pops the next item when the channel is free, with random gaps.
    // The model is advanced on every accepted transaction.
    always @(posedge aclk) begin : stream_driver
        logic           hold_valid;
        int unsigned    eff_size;
        packed_result_t term;
        stream_item_t   queued;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap   = 0;
        end else begin
            hold_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                hold_valid = 1'b0;
                // zero acts as 1, anything above the buffer depth saturates
                eff_size = (group_size_model == 0) ? 1 :
                           (group_size_model > GROUP_CAP) ? GROUP_CAP : group_size_model;
                if (s_tlast) begin
                    // flush a partial group (padded), then the termination result
                    if (held_count > 0)
                        emit_held_group(held_count > eff_size ? held_count : eff_size);
                    term.element    = pfgp_pkg::PAD_ELEMENT;
                    term.group_end  = 1'b0;
                    term.stream_end = 1'b1;
                    expected_results.push_back(term);
                    held_count = 0;
                end else if (is_prime(s_tdata)) begin
                    if (held_count < GROUP_CAP) begin
                        held_primes[held_count] = s_tdata[pfgp_pkg::STORE_W-1:0];
                        held_count++;
                    end
                    // after a size drop, everything held goes out as one group
                    if (held_count >= eff_size)
                        emit_held_group(held_count);
                end
            end
            if (!hold_valid && pending_items.size() != 0) begin
                if (src_gap != 0)
                    src_gap--;
                else if (idling_on && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(0, 6);
                else begin
                    queued     = pending_items.pop_front();
                    s_tdata   <= queued.value;
                    s_tlast   <= queued.eoi;
                    hold_valid = 1'b1;
                end
            end
            s_tvalid <= hold_valid;
        end
    end

    // Result monitor: checks each accepted transaction against the oldest
    // expectation; m_tready is dropped in random bursts.
    always @(posedge aclk) begin : result_monitor
        packed_result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: element %0d last %0b end %0b",
                           $signed(m_tdata), m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.element) begin
                        $error("element: expected %0d, got %0d",
                               $signed(want.element), $signed(m_tdata));
                        mismatch_count++;
                    end
                    if (m_tlast !== want.group_end) begin
                        $error("last_in_group: expected %0b, got %0b", want.group_end, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.stream_end) begin
                        $error("stream_end: expected %0b, got %0b", want.stream_end, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                sink_stall = $urandom_range(0, 6);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("prime_filter_group_packer_top_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset group size of 3: a full group, values at and below 1,
        // field extremes, cheap wide composites, squares, a partial flush,
        // an end marker with nothing held, and end markers whose value is ignored.
        push_item(32'd2, 1'b0);
        push_item(32'd3, 1'b0);
        push_item(32'd5, 1'b0);
        push_item(32'd0, 1'b0);
        push_item(32'd1, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFE, 1'b0);
        push_item(32'h4000_0001, 1'b0);
        push_item(32'd4, 1'b0);
        push_item(32'd9, 1'b0);
        push_item(32'd25, 1'b0);
        push_item(32'd7, 1'b0);
        push_item(32'd65521, 1'b0);
        push_item(32'd13, 1'b1);
        push_item(32'hFFFF_FFFB, 1'b1);
        push_item(32'd11, 1'b0);
        push_item(32'd1048573, 1'b0);
        push_item(32'd17, 1'b0);
        push_item(32'd19, 1'b0);
        push_item(32'd0, 1'b1);

        // zero behaves as a group of one
        set_group_size(6'd0);
        queue_random_items(8, 60, 10, 1'b1);

        // top code saturates to the buffer depth; leave 5 primes held
        set_group_size(6'd63);
        primes_queued = 0;
        queue_random_items(6, 85, 0, 1'b0);
        while (primes_queued % GROUP_CAP != 5)
            push_item(random_prime(), 1'b0);

        // size lowered with primes held: the next prime emits all of them
        set_group_size(6'd2);
        queue_random_items(6, 70, 10, 1'b1);

        // few primes at the largest size: flush pads out to 32
        set_group_size(6'd32);
        repeat (5)
            push_item(random_prime(), 1'b0);
        push_item($urandom, 1'b1);

        set_group_size(6'($urandom_range(33, 62)));
        queue_random_items(5, 70, 10, 1'b1);

        set_group_size(6'd1);
        queue_random_items(6, 60, 10, 1'b1);

        repeat (2) begin
            set_group_size(6'($urandom_range(2, 8)));
            queue_random_items(6, 70, 10, 1'b1);
        end

        // closing stretch with both sides running flat out
        set_group_size(6'($urandom_range(2, 8)));
        idling_on = 1'b0;
        queue_random_items(10, 70, 10, 1'b1);

        wait_until_drained();
        if (mismatch_count == 0)
            $display("prime_filter_group_packer_top_tb: PASS");
        else
            $display("prime_filter_group_packer_top_tb: FAIL");
        $finish;
    end

endmodule : prime_filter_group_packer_top_tb

`default_nettype wire
